>>> hdl/mocb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mocb_pkg: shared types and constants for the motor overcurrent block
// Per-motor state word, staged item, configuration view, result, reg indexes.
// ----------------------------------------------------------------------------
package mocb_pkg;

    localparam int MOTORS_DEF = 4;

    // per-motor state word kept in the state memory
    typedef struct packed {
        logic        was_active;
        logic        blank_armed;
        logic [31:0] blank_deadline;
        logic [31:0] idle_since;
        logic [15:0] over_count;
        logic [31:0] observe_tally;
        logic [31:0] latch_tally;
    } t_mstate;

    localparam t_mstate MSTATE_RESET = '{
        was_active:     1'b0,
        blank_armed:    1'b1,
        blank_deadline: 32'd0,
        idle_since:     32'd0,
        over_count:     16'd0,
        observe_tally:  32'd0,
        latch_tally:    32'd0
    };

    // item as held in the update stage, with time terms worked out ahead
    typedef struct packed {
        logic               in_range;
        logic [1:0]         motor;
        logic [31:0]        now_ms;
        logic               motor_enabled;
        logic               drive_nonzero;
        logic signed [15:0] current_ma;
        logic               sample_valid;
        logic               channel_valid;
        logic [31:0]        now_minus_rearm;
        logic [31:0]        now_plus_blank;
        logic               blank_zero_reached;
        logic               rearm_zero_reached;
    } t_item;

    typedef struct packed {
        logic [63:0] fault_thresholds;
        logic [63:0] observe_thresholds;
        logic [15:0] debounce_ticks;
        logic        fault_enable;
    } t_cfg;

    typedef struct packed {
        logic        overcurrent_latch;
        logic        blanked;
        logic [15:0] over_ticks;
        logic [31:0] observe_count;
        logic [31:0] would_latch_count;
    } t_result;

    typedef enum logic [2:0] {
        REG_FAULT_THR   = 3'd0,
        REG_OBSERVE_THR = 3'd1,
        REG_DEBOUNCE    = 3'd2,
        REG_BLANK_MS    = 3'd3,
        REG_REARM_MS    = 3'd4,
        REG_FAULT_EN    = 3'd5
    } t_reg_idx;

endpackage
`default_nettype wire

>>> hdl/mocb_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mocb_update: per-motor state update
// Blanking, observation tallies and debounce for one item from its old state.
// ----------------------------------------------------------------------------
module mocb_update
    import mocb_pkg::*;
(
    input  wire t_item   i_item,
    input  wire t_mstate i_state,
    input  wire t_cfg    i_cfg,
    output t_mstate      o_state,
    output t_result      o_result
);

    logic               active;
    logic               rearm_hit;
    logic               blanked;
    logic               latch;
    logic [15:0]        deb;
    logic [16:0]        over_inc;
    logic [15:0]        next_cnt;
    logic signed [15:0] fault_thr;
    logic signed [15:0] obs_thr;
    logic [31:0]        idle_gap;
    logic [31:0]        dl_gap;
    t_mstate            st;

    assign fault_thr = signed'(i_cfg.fault_thresholds[{i_item.motor, 4'b0000} +: 16]);
    assign obs_thr   = signed'(i_cfg.observe_thresholds[{i_item.motor, 4'b0000} +: 16]);
    assign deb       = (i_cfg.debounce_ticks == 16'd0) ? 16'd1 : i_cfg.debounce_ticks;
    assign active    = i_item.motor_enabled & i_item.drive_nonzero;
    // sign bit set means the deadline is not reached yet
    assign idle_gap  = i_item.now_minus_rearm - i_state.idle_since;
    assign dl_gap    = i_item.now_ms - i_state.blank_deadline;
    assign over_inc  = {1'b0, i_state.over_count} + 17'd1;

    always_comb begin
        st        = i_state;
        blanked   = 1'b0;
        rearm_hit = 1'b0;
        if (active) begin
            st.idle_since = i_item.now_ms;
            st.was_active = 1'b1;
            if (!i_state.was_active && i_state.blank_armed) begin
                st.blank_deadline = i_item.now_plus_blank;
                st.blank_armed    = 1'b0;
                blanked           = ~i_item.blank_zero_reached;
            end else begin
                blanked = ~i_state.blank_armed & dl_gap[31];
            end
        end else begin
            st.was_active = 1'b0;
            if (i_state.was_active) begin
                st.idle_since = i_item.now_ms;
                rearm_hit     = i_item.rearm_zero_reached;
            end else begin
                rearm_hit     = ~idle_gap[31];
            end
            if (rearm_hit) begin
                st.blank_armed    = 1'b1;
                st.blank_deadline = 32'd0;
                blanked           = 1'b0;
            end else begin
                blanked = ~i_state.blank_armed & dl_gap[31];
            end
        end

        // observation uses the counter from before this item
        if (i_item.sample_valid && i_item.motor_enabled && i_item.channel_valid
                && active && (i_item.current_ma > obs_thr)) begin
            st.observe_tally = i_state.observe_tally + 32'd1;
            if (!i_cfg.fault_enable || (over_inc >= {1'b0, deb})) begin
                st.latch_tally = i_state.latch_tally + 32'd1;
            end
        end

        latch    = 1'b0;
        next_cnt = 16'd0;
        if (i_cfg.fault_enable && i_item.sample_valid && i_item.motor_enabled
                && !blanked && (i_item.current_ma > fault_thr)) begin
            next_cnt = (i_state.over_count < deb) ? over_inc[15:0] : i_state.over_count;
            latch    = (next_cnt >= deb);
        end
        st.over_count = next_cnt;

        o_state = st;
        if (i_item.in_range) begin
            o_result.overcurrent_latch = latch;
            o_result.blanked           = blanked;
            o_result.over_ticks        = st.over_count;
            o_result.observe_count     = st.observe_tally;
            o_result.would_latch_count = st.latch_tally;
        end else begin
            o_result = '0;
        end
    end

endmodule
`default_nettype wire

>>> hdl/motor_overcurrent_blank_debounce.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// motor_overcurrent_blank_debounce: overcurrent detect with startup blanking
// Per-motor blanking window, debounce counter and observation tallies.
// ----------------------------------------------------------------------------
// One sample item per motor per tick enters on the s_axis side and yields one
// result item on the m_axis side. The block takes one item per clock cycle
// whenever the result side keeps up; the accepting edge loads the item
// together with its registered state read, and a later advance of the pipe
// writes the updated state back and loads the output register. Per-motor
// state sits in a single state memory with a registered read; an item that
// follows another item for the same motor gets the freshly written state
// through a forwarding path, so no bubble is needed. Entries start at their
// reset values through per-entry valid bits, so there is no clearing pass
// after reset. Configuration must be written over the APB port (64-bit
// registers at byte address 8*index) only while no item is in flight; the
// block itself does not enforce this. A motor index at or above MOTORS gives
// an all-zero result and leaves every state untouched.
// ----------------------------------------------------------------------------
module motor_overcurrent_blank_debounce
    import mocb_pkg::*;
#(
    parameter int MOTORS = MOTORS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input items
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] now_ms, [32] motor_enabled, [33] drive_nonzero,
    // [49:34] current_ma, [50] sample_valid, [51] channel_valid, [55:52] zero
    input  wire  [55:0] s_axis_tdata,
    // [1:0] motor
    input  wire  [1:0]  s_axis_tuser,
    // result items
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [0] overcurrent_latch, [1] blanked, [17:2] over_ticks,
    // [49:18] observe_count, [81:50] would_latch_count, [87:82] zero
    output logic [87:0] m_axis_tdata,
    // configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [5:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int AW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    // configuration registers
    logic [63:0] r_fault_thr;
    logic [63:0] r_observe_thr;
    logic [15:0] r_debounce;
    logic [31:0] r_blank_ms;
    logic [31:0] r_rearm_ms;
    logic        r_fault_en;

    t_reg_idx    wr_idx;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign wr_idx = t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_thr   <= 64'd0;
            r_observe_thr <= 64'd0;
            r_debounce    <= 16'd1;
            r_blank_ms    <= 32'd1;
            r_rearm_ms    <= 32'd1;
            r_fault_en    <= 1'b0;
        end else if (cfg_wr) begin
            case (wr_idx)
                REG_FAULT_THR:   r_fault_thr   <= pwdata;
                REG_OBSERVE_THR: r_observe_thr <= pwdata;
                REG_DEBOUNCE:    r_debounce    <= pwdata[15:0];
                REG_BLANK_MS:    r_blank_ms    <= pwdata[31:0];
                REG_REARM_MS:    r_rearm_ms    <= pwdata[31:0];
                REG_FAULT_EN:    r_fault_en    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[5:3]))
            REG_FAULT_THR:   prdata = r_fault_thr;
            REG_OBSERVE_THR: prdata = r_observe_thr;
            REG_DEBOUNCE:    prdata = {48'd0, r_debounce};
            REG_BLANK_MS:    prdata = {32'd0, r_blank_ms};
            REG_REARM_MS:    prdata = {32'd0, r_rearm_ms};
            REG_FAULT_EN:    prdata = {63'd0, r_fault_en};
            default:         prdata = 64'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline: whole pipe advances when the output register frees up
    // ------------------------------------------------------------------
    logic        adv;
    logic        acc;
    t_item       n_item;
    logic [31:0] neg_blank;
    logic [31:0] neg_rearm;
    logic [AW-1:0] raddr;
    logic        r_out_valid;
    t_result     r_out;

    assign adv           = ~r_out_valid | m_axis_tready;
    assign s_axis_tready = adv;
    assign acc           = s_axis_tvalid & adv;
    assign raddr         = AW'(s_axis_tuser);
    assign neg_blank     = 32'd0 - r_blank_ms;
    assign neg_rearm     = 32'd0 - r_rearm_ms;

    always_comb begin
        n_item.in_range           = (32'(s_axis_tuser) < MOTORS);
        n_item.motor              = s_axis_tuser;
        n_item.now_ms             = s_axis_tdata[31:0];
        n_item.motor_enabled      = s_axis_tdata[32];
        n_item.drive_nonzero      = s_axis_tdata[33];
        n_item.current_ma         = signed'(s_axis_tdata[49:34]);
        n_item.sample_valid       = s_axis_tdata[50];
        n_item.channel_valid      = s_axis_tdata[51];
        // time terms that need no state: rearm offset and window end
        n_item.now_minus_rearm    = s_axis_tdata[31:0] - r_rearm_ms;
        n_item.now_plus_blank     = s_axis_tdata[31:0] + r_blank_ms;
        n_item.blank_zero_reached = ~neg_blank[31];
        n_item.rearm_zero_reached = ~neg_rearm[31];
    end

    // update stage
    logic          r_s1_valid;
    t_item         r_s1_item;
    t_mstate       r_rdata;
    logic          r_rd_vld;
    logic          r_fwd;
    t_mstate       r_fwd_state;
    t_mstate       cur_state;
    t_mstate       n_state;
    t_result       n_result;
    t_cfg          cfg_view;
    logic [AW-1:0] waddr;
    logic          wr_en;

    t_mstate       r_mem [MOTORS];
    logic [MOTORS-1:0] r_vbit;

    assign cfg_view.fault_thresholds   = r_fault_thr;
    assign cfg_view.observe_thresholds = r_observe_thr;
    assign cfg_view.debounce_ticks     = r_debounce;
    assign cfg_view.fault_enable       = r_fault_en;

    assign waddr = AW'(r_s1_item.motor);
    assign wr_en = adv & r_s1_valid & r_s1_item.in_range;

    // forwarded write beats memory data; never-written entries read as reset
    assign cur_state = r_fwd ? r_fwd_state : (r_rd_vld ? r_rdata : MSTATE_RESET);

    mocb_update u_update (
        .i_item   (r_s1_item),
        .i_state  (cur_state),
        .i_cfg    (cfg_view),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // state memory: one write and one read port, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[waddr] <= n_state;
        end
        if (adv) begin
            r_rdata     <= r_mem[raddr];
            r_fwd_state <= n_state;
            r_s1_item   <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbit     <= '0;
            r_s1_valid <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vbit[waddr] <= 1'b1;
            end
            if (adv) begin
                r_s1_valid <= acc;
                r_rd_vld   <= r_vbit[raddr];
                r_fwd      <= wr_en & (waddr == raddr);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0,
                            r_out.would_latch_count,
                            r_out.observe_count,
                            r_out.over_ticks,
                            r_out.blanked,
                            r_out.overcurrent_latch};

endmodule
`default_nettype wire
